@@ rtl/core/set_assoc_cache_tag_lookup_assert.svh @@
// assertion macros shared by the tag lookup modules
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// full property, clocked on clk, off while arst_n is low
`define SATL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// same-cycle implication
`define SATL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SATL_ASSERT(label, prop, msg)
`define SATL_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/satl_pkg.sv @@
// shared constants and control types of the tag lookup block
package satl_pkg;

	// default geometry; SETS is a power of two
	localparam int WAYS_DEF     = 4;
	localparam int SETS_DEF     = 64;
	localparam int AGE_BITS_DEF = 8;

	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 32;
	localparam int SHIFT_W   = 5;
	localparam int WAY_OUT_W = 2;
	localparam int LFSR_W    = 16;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [LFSR_W-1:0]  LFSR_SEED     = 16'hACE1;
	localparam logic               USE_LRU_RST   = 1'b1;
	localparam logic [SHIFT_W-1:0] OFS_SHIFT_RST = 5'd6;

	typedef enum logic {
		REG_USE_LRU      = 1'b0,
		REG_OFFSET_SHIFT = 1'b1
	} reg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic lookup;
		logic commit;
	} satl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} satl_stat_t;

endpackage

@@ rtl/core/satl_ram.sv @@
// generic single-write, single-read ram with registered read data
module satl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/core/satl_ctrl.sv @@
// sequencing state machine of the tag lookup
`include "set_assoc_cache_tag_lookup_assert.svh"
module satl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	output satl_pkg::satl_cmd_t   cmd,
	input  satl_pkg::satl_stat_t  stat
);
	import satl_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_LOOKUP = 4'b0100,
		ST_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`SATL_ASSERT(a_accept_to_lookup, (state_q == ST_IDLE && req_valid) |=> (state_q == ST_LOOKUP), "accepted request did not start lookup")
	`SATL_ASSERT(a_lookup_to_commit, (state_q == ST_LOOKUP) |=> (state_q == ST_COMMIT), "lookup not followed by commit")
	`SATL_ASSERT_IMPL(a_commit_free, cmd.commit, stat.out_free, "commit while result register busy")
endmodule

@@ rtl/core/satl_dp.sv @@
// tag row memory, hit/victim logic, lfsr and counters
`include "set_assoc_cache_tag_lookup_assert.svh"
module satl_dp #(
	parameter int WAYS     = satl_pkg::WAYS_DEF,
	parameter int SETS     = satl_pkg::SETS_DEF,
	parameter int AGE_BITS = satl_pkg::AGE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  satl_pkg::satl_cmd_t              cmd,
	output satl_pkg::satl_stat_t             stat,
	input  logic                             use_lru,
	input  logic [satl_pkg::SHIFT_W-1:0]     offset_shift,
	input  logic                             mode,
	input  logic [satl_pkg::ADDR_W-1:0]      address,
	input  logic                             rsp_stall,
	output logic                             rsp_valid,
	output logic                             hit,
	output logic [satl_pkg::WAY_OUT_W-1:0]   way_used,
	output logic                             evicted,
	output logic [satl_pkg::CNT_W-1:0]       access_count,
	output logic [satl_pkg::CNT_W-1:0]       read_count,
	output logic [satl_pkg::CNT_W-1:0]       write_count,
	output logic [satl_pkg::CNT_W-1:0]       hit_count,
	output logic [satl_pkg::CNT_W-1:0]       read_hit_count,
	output logic [satl_pkg::CNT_W-1:0]       write_hit_count
);
	import satl_pkg::*;

	localparam int SET_BITS = $clog2(SETS);
	localparam int SET_W    = (SETS > 1) ? SET_BITS : 1;
	localparam int TAG_W    = ADDR_W - SET_BITS;
	localparam int WAY_W    = $clog2(WAYS);
	localparam int PW       = 1 << WAY_W;
	localparam int AGE_OFS  = WAYS;
	localparam int TAG_OFS  = WAYS + WAYS * AGE_BITS;
	localparam int ROW_W    = TAG_OFS + WAYS * TAG_W;
	// lfsr mod WAYS by reciprocal multiply
	localparam int RSH      = LFSR_W + WAY_W;
	localparam int RECIP_W  = LFSR_W + 2;
	localparam int PROD_W   = LFSR_W + RECIP_W;
	localparam logic [RECIP_W-1:0]  RECIP    = RECIP_W'((1 << RSH) / WAYS + 1);
	localparam logic [LFSR_W-1:0]   WAYS_L   = LFSR_W'(WAYS);
	localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;
	localparam logic [SET_W-1:0]    SET_LAST = SET_W'(SETS - 1);
	localparam logic [ADDR_W-1:0]   SET_MASK = ADDR_W'(SETS - 1);

	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
		logic fb;
		fb = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {fb, v[LFSR_W-1:1]};
	endfunction

	logic [SET_W-1:0]  clr_idx_q;
	logic [ADDR_W-1:0] shifted;
	logic [SET_W-1:0]  set_c;
	logic [TAG_W-1:0]  tag_c;
	logic              mode_s1;
	logic [SET_W-1:0]  set_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [ROW_W-1:0]  rd_row;
	logic              ram_we;
	logic [SET_W-1:0]  ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;

	logic [LFSR_W-1:0] lfsr_q, lfsr_nxt, rnd_quot_q, rnd_rem;
	logic [PROD_W-1:0] rnd_prod;
	logic [WAY_W-1:0]  rnd_way;

	logic [WAYS-1:0]     vld, match;
	logic [AGE_BITS-1:0] age [WAYS];
	logic [TAG_W-1:0]    tagw [WAYS];
	logic [AGE_BITS-1:0] t_age [PW];
	logic [WAY_W-1:0]    t_idx [PW];
	logic                hit_c, free_c, evict_c, touch_c, sel;
	logic [WAY_W-1:0]    hit_way, free_way, way_c;
	logic [ROW_W-1:0]    row_c;

	logic [ROW_W-1:0]  row_s2;
	logic              hit_s2, evict_s2;
	logic [WAY_W-1:0]  way_s2;

	logic rsp_valid_q;

	// address split
	assign shifted = address >> offset_shift;
	assign set_c   = SET_W'(shifted & SET_MASK);
	assign tag_c   = TAG_W'(shifted >> SET_BITS);

	assign stat.clear_last = (clr_idx_q == SET_LAST);
	assign stat.out_free   = !rsp_valid_q || !rsp_stall;

	assign ram_we    = cmd.clear || cmd.commit;
	assign ram_waddr = cmd.clear ? clr_idx_q : set_s1;
	assign ram_wdata = cmd.clear ? '0 : row_s2;

	satl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SETS)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.accept),
		.raddr(set_c),
		.rdata(rd_row)
	);

	// random victim: quotient registered, remainder at lookup
	assign lfsr_nxt = lfsr_step(lfsr_q);
	assign rnd_prod = PROD_W'(lfsr_nxt) * PROD_W'(RECIP);

	always_comb begin
		rnd_rem = lfsr_nxt - LFSR_W'(rnd_quot_q * WAYS_L);
		if (rnd_rem >= WAYS_L) begin
			rnd_rem = rnd_rem - WAYS_L;
		end
		rnd_way = WAY_W'(rnd_rem);
	end

	// row unpack and hit search
	always_comb begin
		vld = rd_row[WAYS-1:0];
		for (int i = 0; i < WAYS; i++) begin
			age[i]   = rd_row[AGE_OFS + i * AGE_BITS +: AGE_BITS];
			tagw[i]  = rd_row[TAG_OFS + i * TAG_W +: TAG_W];
			match[i] = vld[i] && (tagw[i] == tag_s1);
		end
		hit_c    = 1'b0;
		hit_way  = '0;
		free_c   = 1'b0;
		free_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_c   = 1'b1;
				hit_way = WAY_W'(i);
			end
			if (!vld[i]) begin
				free_c   = 1'b1;
				free_way = WAY_W'(i);
			end
		end
	end

	// oldest way, lower index wins ties
	always_comb begin
		for (int i = 0; i < PW; i++) begin
			t_idx[i] = WAY_W'(i);
			if (i < WAYS) begin
				t_age[i] = age[i];
			end else begin
				t_age[i] = '0;
			end
		end
		for (int l = 0; l < WAY_W; l++) begin
			for (int i = 0; i < PW / 2; i++) begin
				if (((i << (l + 1)) + (1 << l)) < PW) begin
					if (t_age[(i << (l + 1)) + (1 << l)] > t_age[i << (l + 1)]) begin
						t_age[i << (l + 1)] = t_age[(i << (l + 1)) + (1 << l)];
						t_idx[i << (l + 1)] = t_idx[(i << (l + 1)) + (1 << l)];
					end
				end
			end
		end
	end

	// victim choice and updated row
	always_comb begin
		evict_c = !hit_c && !free_c;
		touch_c = use_lru || evict_c;
		if (hit_c) begin
			way_c = hit_way;
		end else if (free_c) begin
			way_c = free_way;
		end else if (use_lru) begin
			way_c = t_idx[0];
		end else begin
			way_c = rnd_way;
		end
		row_c = rd_row;
		for (int i = 0; i < WAYS; i++) begin
			sel = (WAY_W'(i) == way_c);
			if (sel && !hit_c) begin
				row_c[i]                           = 1'b1;
				row_c[TAG_OFS + i * TAG_W +: TAG_W] = tag_s1;
			end
			if (touch_c) begin
				if (sel) begin
					row_c[AGE_OFS + i * AGE_BITS +: AGE_BITS] = '0;
				end else if (vld[i] && age[i] != AGE_MAX) begin
					row_c[AGE_OFS + i * AGE_BITS +: AGE_BITS] = AGE_BITS'(age[i] + 1'b1);
				end
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		rnd_quot_q <= LFSR_W'(rnd_prod >> RSH);
		if (cmd.accept) begin
			mode_s1 <= mode;
			set_s1  <= set_c;
			tag_s1  <= tag_c;
		end
		if (cmd.lookup) begin
			row_s2   <= row_c;
			hit_s2   <= hit_c;
			way_s2   <= way_c;
			evict_s2 <= evict_c;
		end
		if (cmd.commit) begin
			hit      <= hit_s2;
			way_used <= WAY_OUT_W'(way_s2);
			evicted  <= evict_s2;
		end
	end

	// control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q       <= '0;
			lfsr_q          <= LFSR_SEED;
			rsp_valid_q     <= 1'b0;
			access_count    <= '0;
			read_count      <= '0;
			write_count     <= '0;
			hit_count       <= '0;
			read_hit_count  <= '0;
			write_hit_count <= '0;
		end else begin
			if (cmd.clear) begin
				clr_idx_q <= SET_W'(clr_idx_q + 1'b1);
			end
			if (cmd.lookup && evict_c && !use_lru) begin
				lfsr_q <= lfsr_nxt;
			end
			if (cmd.commit) begin
				rsp_valid_q  <= 1'b1;
				access_count <= CNT_W'(access_count + 1'b1);
				if (mode_s1) begin
					write_count <= CNT_W'(write_count + 1'b1);
				end else begin
					read_count <= CNT_W'(read_count + 1'b1);
				end
				if (hit_s2) begin
					hit_count <= CNT_W'(hit_count + 1'b1);
					if (mode_s1) begin
						write_hit_count <= CNT_W'(write_hit_count + 1'b1);
					end else begin
						read_hit_count <= CNT_W'(read_hit_count + 1'b1);
					end
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	`SATL_ASSERT(a_commit_shows, cmd.commit |=> rsp_valid_q, "commit did not raise rsp_valid")
	`SATL_ASSERT_IMPL(a_evict_full, cmd.lookup && evict_c, &vld, "eviction with a free way in the set")
	`SATL_ASSERT_IMPL(a_hit_no_evict, rsp_valid_q, !(hit && evicted), "hit and eviction together")
	`SATL_ASSERT(a_access_step, cmd.commit |=> (access_count == CNT_W'($past(access_count) + 1'b1)), "access counter did not step")
endmodule

@@ rtl/core/set_assoc_cache_tag_lookup.sv @@
// top level of the set-associative tag lookup with lru or random replacement
//
//  channel  valid      stall      payload
//  req      req_valid  req_stall  mode, address
//  rsp      rsp_valid  rsp_stall  hit, way_used, evicted, six counters
//  apb      psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// a request goes through accept with row read, lookup, commit/write-back
// the registered row read, the lookup register and the row write-back separate those steps
// after reset a clearing pass writes every row, req_stall high
// a request holds in commit while the previous result still waits on rsp_stall
// a new request is taken while a finished result waits in the result register
module set_assoc_cache_tag_lookup #(
	parameter int WAYS     = satl_pkg::WAYS_DEF,
	parameter int SETS     = satl_pkg::SETS_DEF,
	parameter int AGE_BITS = satl_pkg::AGE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [satl_pkg::APB_AW-1:0]      paddr,
	input  logic [satl_pkg::APB_DW-1:0]      pwdata,
	output logic [satl_pkg::APB_DW-1:0]      prdata,
	output logic                             pready,
	// request
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic                             mode,
	input  logic [satl_pkg::ADDR_W-1:0]      address,
	// result
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic                             hit,
	output logic [satl_pkg::WAY_OUT_W-1:0]   way_used,
	output logic                             evicted,
	output logic [satl_pkg::CNT_W-1:0]       access_count,
	output logic [satl_pkg::CNT_W-1:0]       read_count,
	output logic [satl_pkg::CNT_W-1:0]       write_count,
	output logic [satl_pkg::CNT_W-1:0]       hit_count,
	output logic [satl_pkg::CNT_W-1:0]       read_hit_count,
	output logic [satl_pkg::CNT_W-1:0]       write_hit_count
);
	import satl_pkg::*;

	logic               use_lru_q;
	logic [SHIFT_W-1:0] offset_shift_q;
	logic               cfg_wr;
	reg_idx_t           reg_sel;
	satl_cmd_t          cmd;
	satl_stat_t         stat;

	// register index is the word address; byte lanes are ignored
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_lru_q      <= USE_LRU_RST;
			offset_shift_q <= OFS_SHIFT_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_USE_LRU: begin
					use_lru_q <= pwdata[0];
				end
				REG_OFFSET_SHIFT: begin
					offset_shift_q <= pwdata[SHIFT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		case (reg_sel)
			REG_USE_LRU: begin
				prdata = APB_DW'(use_lru_q);
			end
			REG_OFFSET_SHIFT: begin
				prdata = APB_DW'(offset_shift_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// sequencer: clear pass, accept, lookup, commit
	satl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	// row memory, tag compare, replacement choice, counters
	satl_dp #(
		.WAYS    (WAYS),
		.SETS    (SETS),
		.AGE_BITS(AGE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.use_lru        (use_lru_q),
		.offset_shift   (offset_shift_q),
		.mode           (mode),
		.address        (address),
		.rsp_stall      (rsp_stall),
		.rsp_valid      (rsp_valid),
		.hit            (hit),
		.way_used       (way_used),
		.evicted        (evicted),
		.access_count   (access_count),
		.read_count     (read_count),
		.write_count    (write_count),
		.hit_count      (hit_count),
		.read_hit_count (read_hit_count),
		.write_hit_count(write_hit_count)
	);
endmodule

@@ tb/sv/set_assoc_cache_tag_lookup_test.sv @@
// self-checking testbench for the set-associative tag lookup with lru and random replacement
`timescale 1ns / 100ps

module set_assoc_cache_tag_lookup_test;
	import satl_pkg::*;

	// geometry of the default build, mirrored by the predictor
	localparam int NWAYS   = WAYS_DEF;
	localparam int NSETS   = SETS_DEF;
	localparam int AGE_TOP = (1 << AGE_BITS_DEF) - 1;

	// access kinds on the mode port
	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// a request passes through accept, lookup and commit, so the drain covers anything in flight
	localparam int DRAIN_CYCLES = 8;
	// cycles with no handshake at all before giving up; the slowest legal stretches are
	// the clearing pass after reset and the long receiver hold
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct {
		logic              is_write;
		logic [ADDR_W-1:0] addr;
	} access_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 evicted;
		logic [CNT_W-1:0]     n_access;
		logic [CNT_W-1:0]     n_read;
		logic [CNT_W-1:0]     n_write;
		logic [CNT_W-1:0]     n_hit;
		logic [CNT_W-1:0]     n_read_hit;
		logic [CNT_W-1:0]     n_write_hit;
	} lookup_t;

	// clock, reset and the ports of the block
	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [APB_AW-1:0]    paddr   = '0;
	logic [APB_DW-1:0]    pwdata  = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic                 mode      = MODE_READ;
	logic [ADDR_W-1:0]    address   = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic                 hit;
	logic [WAY_OUT_W-1:0] way_used;
	logic                 evicted;
	logic [CNT_W-1:0]     access_count;
	logic [CNT_W-1:0]     read_count;
	logic [CNT_W-1:0]     write_count;
	logic [CNT_W-1:0]     hit_count;
	logic [CNT_W-1:0]     read_hit_count;
	logic [CNT_W-1:0]     write_hit_count;

	// pacing knobs, changed only at the falling edge
	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	logic        hold_tx      = 1'b0;
	logic        hold_rx      = 1'b0;

	// pending requests and the lookup results they must produce, oldest first
	access_t access_q[$];
	lookup_t lookup_results_q[$];
	access_t offered;

	// predictor copy of the tag array, ages, lfsr and running counters
	logic              way_valid [NSETS][NWAYS];
	logic [ADDR_W-1:0] way_tag   [NSETS][NWAYS];
	int unsigned       way_age   [NSETS][NWAYS];
	logic [LFSR_W-1:0] victim_lfsr = LFSR_SEED;
	logic [CNT_W-1:0]  cnt_access = '0, cnt_read = '0, cnt_write = '0;
	logic [CNT_W-1:0]  cnt_hit = '0, cnt_read_hit = '0, cnt_write_hit = '0;

	// predictor copy of the two registers
	logic               cfg_lru   = USE_LRU_RST;
	logic [SHIFT_W-1:0] cfg_shift = OFS_SHIFT_RST;

	// bookkeeping for the summary and the verdict
	int unsigned err_count    = 0;
	int unsigned n_req        = 0;
	int unsigned n_rsp        = 0;
	int unsigned n_fill       = 0;
	int unsigned n_lru_evict  = 0;
	int unsigned n_rand_evict = 0;
	int unsigned n_cfg        = 0;
	int unsigned quiet_cycles = 0;

	always #6 clk = ~clk;

	set_assoc_cache_tag_lookup DUT (.*);

	// used way goes to age zero, every other valid way in the set gets one older
	function automatic void touch_way(int s, int w);
		for (int i = 0; i < NWAYS; i++) begin
			if (i == w)
				way_age[s][i] = 0;
			else if (way_valid[s][i] && way_age[s][i] < AGE_TOP)
				way_age[s][i]++;
		end
	endfunction

	// lookup of one access: updates the tag array copy and returns the expected result
	function automatic lookup_t predict_lookup(access_t a);
		logic [ADDR_W-1:0] shifted;
		logic [ADDR_W-1:0] tag;
		logic              found;
		logic              placed;
		logic              fb;
		int                s;
		int                w;
		lookup_t           r;
		shifted = a.addr >> cfg_shift;
		s       = shifted % NSETS;
		tag     = shifted / NSETS;
		found   = 1'b0;
		placed  = 1'b0;
		w       = 0;
		r       = '0;
		cnt_access++;
		if (a.is_write) cnt_write++; else cnt_read++;

		// lowest matching valid way wins
		for (int i = 0; i < NWAYS; i++) begin
			if (!found && way_valid[s][i] && way_tag[s][i] == tag) begin
				found = 1'b1;
				w     = i;
			end
		end

		if (found) begin
			r.hit = 1'b1;
			cnt_hit++;
			if (a.is_write) cnt_write_hit++; else cnt_read_hit++;
			if (cfg_lru) touch_way(s, w);
		end else begin
			// a miss fills the lowest free way if there is one
			for (int i = 0; i < NWAYS; i++) begin
				if (!placed && !way_valid[s][i]) begin
					placed = 1'b1;
					w      = i;
				end
			end
			if (placed) begin
				way_valid[s][w] = 1'b1;
				way_tag[s][w]   = tag;
				if (cfg_lru) touch_way(s, w);
				n_fill++;
			end else begin
				if (cfg_lru) begin
					// oldest way, lowest index on a tie
					w = 0;
					for (int i = 1; i < NWAYS; i++)
						if (way_age[s][i] > way_age[s][w]) w = i;
					n_lru_evict++;
				end else begin
					// one lfsr step, taps 16/14/13/11, shifting right
					fb          = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
					victim_lfsr = {fb, victim_lfsr[LFSR_W-1:1]};
					w           = int'(victim_lfsr % NWAYS);
					n_rand_evict++;
				end
				r.evicted     = 1'b1;
				way_tag[s][w] = tag;
				// replacement ages the set in both modes
				touch_way(s, w);
			end
		end

		r.way         = WAY_OUT_W'(w);
		r.n_access    = cnt_access;
		r.n_read      = cnt_read;
		r.n_write     = cnt_write;
		r.n_hit       = cnt_hit;
		r.n_read_hit  = cnt_read_hit;
		r.n_write_hit = cnt_write_hit;
		return r;
	endfunction

	task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// request driver: offers the next pending access once the previous one is taken
	always @(posedge clk) begin : drive_req
		logic taken;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			taken = req_valid && !req_stall;
			if (taken) begin
				lookup_results_q.push_back(predict_lookup(offered));
				n_req++;
			end
			// payload only changes once the current request is gone
			if (!req_valid || taken) begin
				if (access_q.size() != 0 && !hold_tx && $urandom_range(99) >= tx_idle_pct) begin
					offered = access_q.pop_front();
					req_valid <= 1'b1;
					mode      <= offered.is_write;
					address   <= offered.addr;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: every accepted result is matched against the oldest prediction
	always @(posedge clk) begin : watch_rsp
		lookup_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				n_rsp++;
				if (lookup_results_q.size() == 0) begin
					err_count++;
					$display("%0t unexpected result: hit %0b way %0d evicted %0b",
						$time, hit, way_used, evicted);
				end else begin
					want = lookup_results_q.pop_front();
					check_field("hit", CNT_W'(want.hit), CNT_W'(hit));
					check_field("way_used", CNT_W'(want.way), CNT_W'(way_used));
					check_field("evicted", CNT_W'(want.evicted), CNT_W'(evicted));
					check_field("access_count", want.n_access, access_count);
					check_field("read_count", want.n_read, read_count);
					check_field("write_count", want.n_write, write_count);
					check_field("hit_count", want.n_hit, hit_count);
					check_field("read_hit_count", want.n_read_hit, read_hit_count);
					check_field("write_hit_count", want.n_write_hit, write_hit_count);
				end
			end
			rsp_stall <= hold_rx || ($urandom_range(99) < rx_stall_pct);
		end
	end

	// watchdog: any handshake or register access counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t no handshake for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, lookup_results_q.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// apb write: setup cycle, access cycle, register taken at the edge with pready high
	task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_USE_LRU) cfg_lru = val[0];
		else cfg_shift = val[SHIFT_W-1:0];
		n_cfg++;
	endtask

	task automatic set_config(logic lru, logic [SHIFT_W-1:0] shift);
		write_reg(REG_USE_LRU, APB_DW'(lru));
		write_reg(REG_OFFSET_SHIFT, APB_DW'(shift));
	endtask

	// idle means nothing queued, nothing offered and every prediction matched
	task automatic wait_idle();
		do @(negedge clk);
		while (access_q.size() != 0 || req_valid || lookup_results_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic void queue_access(logic is_write, logic [ADDR_W-1:0] a);
		access_t x;
		x.is_write = is_write;
		x.addr     = a;
		access_q.push_back(x);
	endfunction

	// byte address that lands on set s with the given tag under the current shift,
	// random bits below the shift
	function automatic logic [ADDR_W-1:0] place_addr(int s, logic [ADDR_W-1:0] tag);
		logic [63:0] line;
		logic [63:0] low;
		line = (64'(tag) * NSETS + 64'(s % NSETS)) << cfg_shift;
		low  = {32'd0, $urandom} & ((64'd1 << cfg_shift) - 64'd1);
		return ADDR_W'(line | low);
	endfunction

	// mostly accesses confined to a few sets and a small tag pool so that fills,
	// hits and evictions all recur; the rest is fully random addresses
	task automatic run_random(int count, int n_sets, int n_tags);
		int                set_base;
		logic [ADDR_W-1:0] tag_base;
		set_base = $urandom_range(NSETS - 1);
		tag_base = ($urandom_range(3) == 0) ? '0 : ADDR_W'($urandom);
		@(negedge clk);
		repeat (count) begin
			if ($urandom_range(99) < 15)
				queue_access(1'($urandom_range(1)), $urandom);
			else
				queue_access(1'($urandom_range(1)),
					place_addr(set_base + $urandom_range(n_sets - 1),
					tag_base + $urandom_range(n_tags - 1)));
		end
	endtask

	// lru ageing to saturation: fill one set with four tags, then hammer three of
	// them so the fourth reaches the top age, then force it out
	task automatic run_age_saturation();
		int                s;
		logic [ADDR_W-1:0] tb;
		s  = $urandom_range(NSETS - 1);
		tb = $urandom;
		@(negedge clk);
		for (int k = 0; k < NWAYS; k++)
			queue_access(1'($urandom_range(1)), place_addr(s, tb + k));
		repeat (300)
			queue_access(1'($urandom_range(1)), place_addr(s, tb + $urandom_range(NWAYS - 2)));
		queue_access(MODE_READ, place_addr(s, tb + NWAYS));
		queue_access(MODE_WRITE, place_addr(s, tb + NWAYS - 1));
	endtask

	initial begin
		int unsigned mark;
		for (int s = 0; s < NSETS; s++)
			for (int w = 0; w < NWAYS; w++) begin
				way_valid[s][w] = 1'b0;
				way_tag[s][w]   = '0;
				way_age[s][w]   = 0;
			end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset settings (lru, shift 6): fills of every way,
		// read and write hits, lru eviction, address extremes
		@(negedge clk);
		queue_access(MODE_READ, 32'h0000_0000);
		queue_access(MODE_WRITE, 32'hFFFF_FFFF);
		queue_access(MODE_READ, place_addr(0, 0));
		queue_access(MODE_WRITE, place_addr(0, 1));
		queue_access(MODE_READ, place_addr(0, 2));
		queue_access(MODE_WRITE, place_addr(0, 3));
		queue_access(MODE_WRITE, place_addr(0, 1));
		queue_access(MODE_READ, place_addr(0, 4));
		queue_access(MODE_READ, place_addr(0, 0));
		queue_access(MODE_READ, 32'hFFFF_FFC0);
		queue_access(MODE_WRITE, 32'hFFFF_FFFF);
		queue_access(MODE_READ, 32'h0000_0FFF);
		queue_access(MODE_WRITE, 32'h8000_0000);
		queue_access(MODE_READ, 32'h7FFF_FFFF);
		queue_access(MODE_WRITE, place_addr(0, 4));
		queue_access(MODE_READ, 32'h0000_003F);
		wait_idle();

		// lru with no shift, no idling at all
		set_config(1'b1, 5'd0);
		run_random(200, 3, 7);
		wait_idle();

		// random replacement, sender mostly idle
		tx_idle_pct = 85;
		set_config(1'b0, 5'd6);
		run_random(200, 2, 6);
		wait_idle();

		// random replacement at the largest shift, receiver mostly stalling
		tx_idle_pct  = 0;
		rx_stall_pct = 85;
		set_config(1'b0, 5'd31);
		run_random(150, 2, 5);
		wait_idle();

		// lru, both sides idling now and then
		tx_idle_pct  = 36;
		rx_stall_pct = 36;
		set_config(1'b1, 5'd13);
		run_random(230, 4, 8);
		wait_idle();

		// back pressure: receiver holds off for a long stretch while the sender keeps
		// offering, then the sender pauses until every result is back
		tx_idle_pct  = 0;
		rx_stall_pct = 20;
		set_config(1'b0, 5'd9);
		mark = n_req;
		run_random(150, 2, 6);
		hold_rx = 1'b1;
		repeat (60) @(negedge clk);
		hold_rx = 1'b0;
		do @(negedge clk); while (n_req < mark + 100);
		hold_tx = 1'b1;
		do @(negedge clk); while (lookup_results_q.size() != 0);
		hold_tx = 1'b0;
		wait_idle();

		// age saturation under lru, both sides idling
		tx_idle_pct  = 36;
		rx_stall_pct = 36;
		set_config(1'b1, 5'd6);
		run_age_saturation();
		wait_idle();

		$display("covered %0d requests and %0d results: %0d hits, %0d fills,",
			n_req, n_rsp, cnt_hit, n_fill);
		$display("%0d lru and %0d random evictions, %0d register writes over both modes",
			n_lru_evict, n_rand_evict, n_cfg);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/satl_pkg.sv
rtl/core/satl_ram.sv
rtl/core/satl_ctrl.sv
rtl/core/satl_dp.sv
rtl/core/set_assoc_cache_tag_lookup.sv
tb/sv/set_assoc_cache_tag_lookup_test.sv
